### design/tlpt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the two-level page table engine.
// No dependencies; tlpt_walker and the top level import this package.
package tlpt_pkg;

    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_MAP    = 2'd1;
    localparam logic [1:0] FUNC_UNMAP  = 2'd2;

    localparam int DIR_IDX_W   = 10;
    localparam int TBL_IDX_W   = 10;
    localparam int FRAME_W     = 20;
    localparam int PAGE_OFF_W  = 12;
    localparam int PTE_W       = FRAME_W + 3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIR,
        ST_TBL
    } t_state;

    typedef struct packed {
        logic        status;
        logic [31:0] phys_addr;
        logic        present;
    } t_res;

endpackage

### design/tlpt_ram.sv
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
module tlpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/tlpt_walker.sv
`timescale 1ns / 1ps
// Request sequencer: clearing pass, directory read, table read or write.
// Depends on tlpt_pkg; drives the directory and table RAM ports.
module tlpt_walker import tlpt_pkg::*; #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_func,
    input  logic [31:0]              i_va,
    input  logic [FRAME_W-1:0]       i_frame,
    input  logic                     i_user,
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output t_res                     o_res,
    output logic                     o_dir_we,
    output logic [DIR_IDX_W-1:0]     o_dir_addr,
    output logic [((TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1)+2:0] o_dir_wdata,
    input  logic [((TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1)+2:0] i_dir_rdata,
    output logic                     o_tbl_we,
    output logic [$clog2(TABLE_SLOTS*1024)-1:0] o_tbl_addr,
    output logic [PTE_W-1:0]         o_tbl_wdata,
    input  logic [PTE_W-1:0]         i_tbl_rdata
);

    localparam int SW  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int TAW = $clog2(TABLE_SLOTS * 1024);
    localparam int NW  = $clog2(TABLE_SLOTS + 1);
    localparam logic [TAW-1:0] CLR_LAST  = TAW'(TABLE_SLOTS * 1024 - 1);
    localparam logic [NW-1:0]  SLOTS_MAX = NW'(TABLE_SLOTS);

    t_state               r_state, n_state;
    logic [1:0]           r_func;
    logic [31:0]          r_va;
    logic [FRAME_W-1:0]   r_frame;
    logic                 r_user;
    logic [NW-1:0]        r_next, n_next;
    logic [TAW-1:0]       r_clr, n_clr;

    logic                 dir_present;
    logic [SW-1:0]        dir_slot;
    logic                 slot_free;
    logic [SW-1:0]        sel_slot;
    logic [SW+TBL_IDX_W-1:0] tbl_full_addr;
    logic                 is_lookup, is_map, is_unmap;
    logic                 alloc;

    assign dir_present = i_dir_rdata[0];
    assign dir_slot    = i_dir_rdata[SW+2:3];
    assign slot_free   = (r_next != SLOTS_MAX);
    assign is_lookup   = (r_func == FUNC_LOOKUP);
    assign is_map      = (r_func == FUNC_MAP);
    assign is_unmap    = (r_func == FUNC_UNMAP);
    assign sel_slot    = dir_present ? dir_slot : SW'(r_next);
    assign tbl_full_addr = {sel_slot, r_va[21:12]};
    assign alloc = (r_state == ST_DIR) && i_res_ready && is_map && !dir_present && slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_next  <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_next  <= n_next;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_func  <= i_func;
            r_va    <= i_va;
            r_frame <= i_frame;
            r_user  <= i_user;
        end
    end

    always_comb begin
        n_state = r_state;
        n_next  = r_next;
        n_clr   = r_clr;
        case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_DIR;
                end
            end
            ST_DIR: begin
                if (is_lookup && dir_present) begin
                    n_state = ST_TBL;
                end else if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
                if (alloc) begin
                    n_next = r_next + 1'b1;
                end
            end
            ST_TBL: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_dir_we    = 1'b0;
        o_dir_addr  = r_va[31:22];
        o_dir_wdata = '0;
        o_tbl_we    = 1'b0;
        o_tbl_addr  = tbl_full_addr[TAW-1:0];
        o_tbl_wdata = '0;
        case (r_state)
            ST_CLEAR: begin
                o_dir_we   = 1'b1;
                o_dir_addr = r_clr[DIR_IDX_W-1:0];
                o_tbl_we   = 1'b1;
                o_tbl_addr = r_clr;
            end
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_dir_addr = i_va[31:22];
            end
            ST_DIR: begin
                o_res_valid   = !(is_lookup && dir_present);
                o_res.status  = is_map && !dir_present && !slot_free;
                o_dir_we      = alloc;
                o_dir_wdata   = {SW'(r_next), 3'b111};
                if (i_res_ready) begin
                    if (is_map && (dir_present || slot_free)) begin
                        o_tbl_we    = 1'b1;
                        o_tbl_wdata = {r_frame, r_user, 2'b11};
                    end else if (is_unmap && dir_present) begin
                        o_tbl_we    = 1'b1;
                    end
                end
            end
            ST_TBL: begin
                o_res_valid     = 1'b1;
                o_res.present   = i_tbl_rdata[0];
                o_res.phys_addr = i_tbl_rdata[0] ?
                                  {i_tbl_rdata[PTE_W-1:3], r_va[PAGE_OFF_W-1:0]} : '0;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

### design/two_level_page_table_engine_unit.sv
`timescale 1ns / 1ps
// Top level of the two-level page table engine: RAMs, sequencer, output register.
// Depends on tlpt_pkg, tlpt_ram and tlpt_walker.
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: virt_addr, phys_frame, user_page
//                                             tuser: func
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: present, phys_addr, status
//
// A map, an unmap or a lookup of an absent directory entry completes in the directory
// read state; a lookup that reaches a page table goes on to a page table read. The
// directory read comes before the dependent page table access; each is a single-port
// RAM with a registered read. After reset a clearing pass zeroes both RAMs with tready low.
// A result waiting in the output register does not block the next request; the
// sequencer holds in its final state only while that register is full and not taken.
module two_level_page_table_engine_unit import tlpt_pkg::*; #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // virt_addr[31:0], phys_frame[51:32], user_page[52]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // present[0], phys_addr[32:1], status[33]
);

    localparam int SW  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int DW  = SW + 3;
    localparam int TAW = $clog2(TABLE_SLOTS * 1024);

    logic               res_valid;
    logic               res_ready;
    t_res               res;
    logic               dir_we;
    logic [DIR_IDX_W-1:0] dir_addr;
    logic [DW-1:0]      dir_wdata;
    logic [DW-1:0]      dir_rdata;
    logic               tbl_we;
    logic [TAW-1:0]     tbl_addr;
    logic [PTE_W-1:0]   tbl_wdata;
    logic [PTE_W-1:0]   tbl_rdata;

    logic               r_m_valid;
    t_res               r_m_res;

    tlpt_ram #(
        .WIDTH (DW),
        .DEPTH (1024)
    ) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_addr  (dir_addr),
        .i_wdata (dir_wdata),
        .o_rdata (dir_rdata)
    );

    tlpt_ram #(
        .WIDTH (PTE_W),
        .DEPTH (TABLE_SLOTS * 1024)
    ) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_addr  (tbl_addr),
        .i_wdata (tbl_wdata),
        .o_rdata (tbl_rdata)
    );

    tlpt_walker #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_func      (s_axis_tuser),
        .i_va        (s_axis_tdata[31:0]),
        .i_frame     (s_axis_tdata[51:32]),
        .i_user      (s_axis_tdata[52]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_dir_we    (dir_we),
        .o_dir_addr  (dir_addr),
        .o_dir_wdata (dir_wdata),
        .i_dir_rdata (dir_rdata),
        .o_tbl_we    (tbl_we),
        .o_tbl_addr  (tbl_addr),
        .o_tbl_wdata (tbl_wdata),
        .i_tbl_rdata (tbl_rdata)
    );

    assign res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_m_res <= res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'd0, r_m_res};

endmodule

### verif/page_walk_checker.sv
`timescale 1ns / 1ps
// Checker for the two-level page table engine: watches both stream channels, keeps
// its own copy of the directory and page tables, and compares every result it sees.
// Depends on tlpt_pkg.
module page_walk_checker import tlpt_pkg::*; #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,   // virt_addr[31:0], phys_frame[51:32], user_page[52]
    input  logic [1:0]  i_s_axis_tuser,   // func[1:0]
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [39:0] i_m_axis_tdata,   // present[0], phys_addr[32:1], status[33]
    output int          o_fail_count,
    output int          o_pending
);

    localparam int DIR_ENTRIES   = 1 << DIR_IDX_W;
    localparam int TBL_ENTRIES   = 1 << TBL_IDX_W;
    localparam int TABLE_ENTRIES = TABLE_SLOTS * TBL_ENTRIES;

    logic               dir_present [DIR_ENTRIES];
    int unsigned        dir_slot    [DIR_ENTRIES];
    logic               pte_present [TABLE_ENTRIES];
    logic [FRAME_W-1:0] pte_frame   [TABLE_ENTRIES];
    int unsigned        slots_used;

    t_res pending_walk_results [$];
    t_res got;
    t_res want;
    int   fails = 0;

    function automatic t_res walk_page_tables(input logic [1:0] op, input logic [31:0] va,
                                              input logic [FRAME_W-1:0] frame);
        t_res        r;
        int unsigned di;
        int unsigned ti;
        int unsigned base;
        r    = '0;
        di   = 32'(va[31:22]);
        ti   = 32'(va[21:12]);
        case (op)
            FUNC_LOOKUP: begin
                if (dir_present[di] && dir_slot[di] < TABLE_SLOTS) begin
                    base = dir_slot[di] * TBL_ENTRIES;
                    if (pte_present[base + ti]) begin
                        r.present   = 1'b1;
                        r.phys_addr = {pte_frame[base + ti], va[PAGE_OFF_W-1:0]};
                    end
                end
            end
            FUNC_MAP: begin
                if (!dir_present[di]) begin
                    if (slots_used >= TABLE_SLOTS) begin
                        r.status = 1'b1;
                    end else begin
                        base = slots_used * TBL_ENTRIES;
                        for (int k = 0; k < TBL_ENTRIES; k++) begin
                            pte_present[base + k] = 1'b0;
                            pte_frame[base + k]   = '0;
                        end
                        dir_present[di] = 1'b1;
                        dir_slot[di]    = slots_used;
                        slots_used++;
                    end
                end
                if (!r.status && dir_slot[di] < TABLE_SLOTS) begin
                    base = dir_slot[di] * TBL_ENTRIES;
                    pte_present[base + ti] = 1'b1;
                    pte_frame[base + ti]   = frame;
                end
            end
            FUNC_UNMAP: begin
                if (dir_present[di] && dir_slot[di] < TABLE_SLOTS) begin
                    base = dir_slot[di] * TBL_ENTRIES;
                    pte_present[base + ti] = 1'b0;
                    pte_frame[base + ti]   = '0;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIR_ENTRIES; k++) begin
                dir_present[k] = 1'b0;
                dir_slot[k]    = 0;
            end
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                pte_present[k] = 1'b0;
                pte_frame[k]   = '0;
            end
            slots_used = 0;
            pending_walk_results.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = i_m_axis_tdata[33:0];
                if (pending_walk_results.size() == 0) begin
                    $error("Result with no request outstanding: tdata %h", i_m_axis_tdata);
                    fails++;
                end else begin
                    want = pending_walk_results.pop_front();
                    if (got.present !== want.present) begin
                        $error("present: expected %0d, actual %0d", want.present, got.present);
                        fails++;
                    end
                    if (got.phys_addr !== want.phys_addr) begin
                        $error("phys_addr: expected %h, actual %h", want.phys_addr,
                               got.phys_addr);
                        fails++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        fails++;
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                pending_walk_results.push_back(walk_page_tables(i_s_axis_tuser,
                    i_s_axis_tdata[31:0], i_s_axis_tdata[51:32]));
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_walk_results.size();
    end

endmodule

### verif/two_level_page_table_engine_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the two-level page table engine: clock, reset, request stimulus,
// random back-pressure and the final verdict. Depends on tlpt_pkg, the engine and
// page_walk_checker.
module two_level_page_table_engine_unit_tb import tlpt_pkg::*;;

    localparam int          TABLE_SLOTS    = 16;
    localparam int          RAND_PER_PHASE = 234;
    localparam int          HOLD_CYCLES    = 200;
    localparam int          DRAIN_CYCLES   = 12;
    localparam logic [1:0]  FUNC_RESERVED  = 2'd3;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;   // virt_addr[31:0], phys_frame[51:32], user_page[52]
    logic [1:0]  s_axis_tuser  = '0;   // func[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // present[0], phys_addr[32:1], status[33]

    int fail_count;
    int pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int holds_asked = 0;
    int holds_done  = 0;

    int unsigned dir_pool [18] = '{0, 1023, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14,
                                   512, 700};

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    two_level_page_table_engine_unit #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    page_walk_checker #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    task automatic send_page_request(input logic [1:0] op, input logic [31:0] va,
                                     input logic [FRAME_W-1:0] frame, input logic user);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, user, frame, va};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // The receiver either follows the current idle rate or, when asked, holds off for a
    // long stretch so that the engine backs up into its input.
    initial begin
        forever begin
            @(posedge i_clk);
            if (holds_done != holds_asked) begin
                holds_done++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int unsigned      roll;
        logic [1:0]       op;
        logic [9:0]       di;
        logic [9:0]       ti;
        logic [11:0]      off;
        logic [31:0]      va;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_page_request(FUNC_LOOKUP, 32'h0000_0000, '0, 1'b0);
        send_page_request(FUNC_UNMAP, 32'hFFFF_FFFF, '1, 1'b1);
        send_page_request(FUNC_MAP, 32'h0000_0000, '0, 1'b0);
        send_page_request(FUNC_LOOKUP, 32'h0000_0FFF, '0, 1'b0);
        send_page_request(FUNC_MAP, 32'hFFFF_F000, '1, 1'b1);
        send_page_request(FUNC_LOOKUP, 32'hFFFF_FFFF, '0, 1'b0);
        send_page_request(FUNC_UNMAP, 32'hFFFF_E000, '0, 1'b0);
        send_page_request(FUNC_MAP, 32'h0000_0000, 20'h12345, 1'b1);
        send_page_request(FUNC_LOOKUP, 32'h0000_0ABC, '0, 1'b0);
        send_page_request(FUNC_UNMAP, 32'h0000_0000, '0, 1'b0);
        send_page_request(FUNC_LOOKUP, 32'h0000_0000, '0, 1'b0);
        send_page_request(FUNC_RESERVED, 32'hFFFF_FFFF, '1, 1'b1);
        // Use up the remaining table slots, then ask for one more.
        for (int k = 1; k <= TABLE_SLOTS - 2; k++) begin
            send_page_request(FUNC_MAP, {10'(k), 10'(k), 12'h000}, 20'(k), 1'b0);
        end
        send_page_request(FUNC_MAP, {10'd512, 10'd0, 12'h000}, 20'hABCDE, 1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct <= (phase == 0) ? 24 : (phase == 1) ? 76 : 0;
            rx_idle_pct <= (phase == 0) ? 76 : (phase == 1) ? 24 : 0;
            if (phase == 2) begin
                holds_asked <= holds_asked + 1;
            end
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                roll = $urandom_range(99);
                if (roll < 45) begin
                    op = FUNC_LOOKUP;
                end else if (roll < 75) begin
                    op = FUNC_MAP;
                end else if (roll < 95) begin
                    op = FUNC_UNMAP;
                end else begin
                    op = FUNC_RESERVED;
                end
                di  = 10'(dir_pool[$urandom_range(17)]);
                ti  = ($urandom_range(3) == 0) ? 10'($urandom_range(1023)) :
                                                 10'($urandom_range(7));
                off = 12'($urandom);
                va  = ($urandom_range(9) < 8) ? {di, ti, off} : $urandom;
                send_page_request(op, va, 20'($urandom), 1'($urandom));
            end
        end
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
design/tlpt_pkg.sv
design/tlpt_ram.sv
design/tlpt_walker.sv
design/two_level_page_table_engine_unit.sv
verif/page_walk_checker.sv
verif/two_level_page_table_engine_unit_tb.sv
